>>> rtl/core/scs_pkg.sv
// Shared types, constants and lookup tables for the sound channel synthesizer.
// No dependencies; every other file of the block but scs_if imports it.
`timescale 1ns / 1ps
package scs_pkg;

	// Default configuration of the top level
	localparam int TICKS_PER_FRAME_DEF = 735;
	localparam int PHASE_BITS_DEF      = 24;

	// Clock figures used for the oscillator steps
	localparam int CPU_HZ    = 1789773;
	localparam int MIX_HZ    = 44100;
	localparam int NOISE_INC = CPU_HZ / MIX_HZ;
	localparam int CPU_HZ_W  = 21;
	localparam int DEN_W     = 32;

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Sub-register of a pulse channel (low two address bits)
	localparam logic [1:0] PULSE_CTL   = 2'd0;
	localparam logic [1:0] PULSE_SWEEP = 2'd1;
	localparam logic [1:0] PULSE_LO    = 2'd2;
	localparam logic [1:0] PULSE_HI    = 2'd3;

	// Sound register numbers above the pulse block
	localparam logic [3:0] REG_PULSE_LAST = 4'd7;
	localparam logic [3:0] REG_TRI_LIN    = 4'd8;
	localparam logic [3:0] REG_TRI_LO     = 4'd10;
	localparam logic [3:0] REG_TRI_HI     = 4'd11;
	localparam logic [3:0] REG_NOISE_CTL  = 4'd12;
	localparam logic [3:0] REG_NOISE_MODE = 4'd14;
	localparam logic [3:0] REG_NOISE_ENV  = 4'd15;

	// Configuration register indexes
	localparam logic CFG_CHANNEL_ENABLE = 1'b0;
	localparam logic CFG_PLAY_ENABLE    = 1'b1;

	// One input word
	typedef struct packed {
		logic       kind;
		logic [3:0] reg_addr;
		logic [7:0] reg_data;
	} item_t;

	// Front queue head as seen by the back end
	typedef struct packed {
		logic  avail;
		item_t item;
	} fq_t;

	// Request to the step divider
	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Envelope unit state
	typedef struct packed {
		logic [3:0] level;
		logic [4:0] div;
	} env_t;

	// Level to Q8 gain, (256 * v + 7) / 15
	function automatic logic [8:0] gain_q8(input logic [3:0] v);
		logic [8:0] g;
		case (v)
			4'd0:    g = 9'd0;
			4'd1:    g = 9'd17;
			4'd2:    g = 9'd34;
			4'd3:    g = 9'd51;
			4'd4:    g = 9'd68;
			4'd5:    g = 9'd85;
			4'd6:    g = 9'd102;
			4'd7:    g = 9'd119;
			4'd8:    g = 9'd137;
			4'd9:    g = 9'd154;
			4'd10:   g = 9'd171;
			4'd11:   g = 9'd188;
			4'd12:   g = 9'd205;
			4'd13:   g = 9'd222;
			4'd14:   g = 9'd239;
			default: g = 9'd256;
		endcase
		return g;
	endfunction

	// Noise period table
	function automatic logic [11:0] noise_period(input logic [3:0] i);
		logic [11:0] p;
		case (i)
			4'd0:    p = 12'd4;
			4'd1:    p = 12'd8;
			4'd2:    p = 12'd16;
			4'd3:    p = 12'd32;
			4'd4:    p = 12'd64;
			4'd5:    p = 12'd96;
			4'd6:    p = 12'd128;
			4'd7:    p = 12'd160;
			4'd8:    p = 12'd202;
			4'd9:    p = 12'd254;
			4'd10:   p = 12'd380;
			4'd11:   p = 12'd508;
			4'd12:   p = 12'd762;
			4'd13:   p = 12'd1016;
			4'd14:   p = 12'd2034;
			default: p = 12'd4068;
		endcase
		return p;
	endfunction

	// Duty in eighths of a period
	function automatic logic [2:0] duty_eighths(input logic [1:0] d);
		logic [2:0] e;
		case (d)
			2'd0:    e = 3'd1;
			2'd1:    e = 3'd2;
			2'd2:    e = 3'd4;
			default: e = 3'd6;
		endcase
		return e;
	endfunction

endpackage

>>> rtl/core/scs_if.sv
// Handshake channels of the sound channel synthesizer: input items and samples.
// No dependencies.
`timescale 1ns / 1ps
interface scs_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [3:0] reg_addr;
	logic [7:0] reg_data;

	modport source (output valid, kind, reg_addr, reg_data, input ready);
	modport sink (input valid, kind, reg_addr, reg_data, output ready);
endinterface

interface scs_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink (input valid, left_sample, right_sample, output ready);
endinterface

>>> rtl/core/sound_channel_synthesizer.sv
// Top level of the four-channel sound synthesizer (two pulses, triangle, noise).
// Depends on scs_pkg, scs_if, scs_front, scs_div and scs_back.
//
//  channel  | dir | handshake     | word
//  in_ch    | in  | valid/ready   | kind, reg_addr[3:0], reg_data[7:0]
//  out_ch   | out | valid/ready   | left_sample[15:0], right_sample[15:0] (signed)
//  cfg      | in  | cfg_we        | cfg_index, cfg_data[3:0]
//
// A period write also runs the one-bit-per-cycle step divider.
// A tick steps the noise LFSR once for each noise period in its accumulator and
// runs the step divider again for each pulse whose sweep changes the period (up to two).
// Reset is asynchronous and clears all channel state at once; no clearing pass.
// The input queue holds two words and keeps taking them while the back end
// works or a finished sample waits in the output register.
`timescale 1ns / 1ps
module sound_channel_synthesizer
	import scs_pkg::*;
#(
	parameter int TICKS_PER_FRAME = TICKS_PER_FRAME_DEF,
	parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	scs_in_if.sink     in_ch,
	scs_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);

	fq_t                   head;
	logic                  pop;
	div_req_t              div_req;
	logic                  div_done;
	logic [PHASE_BITS-1:0] div_quo;

	scs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	scs_div #(
		.PHASE_BITS (PHASE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	scs_back #(
		.TICKS_PER_FRAME (TICKS_PER_FRAME),
		.PHASE_BITS      (PHASE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_quo   (div_quo),
		.out_ch    (out_ch)
	);

endmodule

>>> rtl/core/scs_front.sv
// Front end: takes input words and holds them in a two-entry queue.
// Depends on scs_pkg and scs_in_if.
`timescale 1ns / 1ps
module scs_front
	import scs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	scs_in_if.sink     in_ch,
	input  logic       pop,
	output fq_t        head
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head.avail  = (cnt_q != 2'd0);
	assign head.item   = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{kind: in_ch.kind, reg_addr: in_ch.reg_addr,
				reg_data: in_ch.reg_data};
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/scs_div.sv
// Step divider: (CPU_HZ << PHASE_BITS) / den, one quotient bit per cycle.
// Depends on scs_pkg. Keeps the low PHASE_BITS bits of the quotient.
`timescale 1ns / 1ps
module scs_div
	import scs_pkg::*;
#(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  done,
	output logic [PHASE_BITS-1:0] quo
);

	localparam int NUM_W = CPU_HZ_W + PHASE_BITS;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [NUM_W-1:0] NUM = {CPU_HZ_W'(CPU_HZ), {PHASE_BITS{1'b0}}};

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DEN_W-1:0]      den_q;
	logic [PHASE_BITS-1:0] quo_q;
	logic [DEN_W:0]        trial;
	logic                  ge;

	assign done = done_q;
	assign quo  = quo_q;

	// one restoring step
	assign trial = {rem_q, NUM[cnt_q]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[PHASE_BITS-2:0], ge};
		end
	end

endmodule

>>> rtl/core/scs_back.sv
// Back end: sound state, register writes and the per-tick sample sequencer.
// Depends on scs_pkg, scs_out_if; drives the step divider scs_div.
`timescale 1ns / 1ps
module scs_back
	import scs_pkg::*;
#(
	parameter int TICKS_PER_FRAME = TICKS_PER_FRAME_DEF,
	parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [3:0]            cfg_data,
	input  fq_t                   head,
	output logic                  pop,
	output div_req_t              div_req,
	input  logic                  div_done,
	input  logic [PHASE_BITS-1:0] div_quo,
	scs_out_if.source             out_ch
);

	localparam int ENV_DIV = TICKS_PER_FRAME / 4;
	localparam int SWP_DIV = TICKS_PER_FRAME / 2;
	localparam int TC_W    = $clog2(TICKS_PER_FRAME);
	localparam int EC_W    = $clog2(ENV_DIV);
	localparam int SC_W    = $clog2(SWP_DIV);
	localparam int ACC_W   = 28;
	localparam int PROD_W  = 25;
	localparam int MUL_W   = 42;

	localparam logic signed [ACC_W-1:0] W_OWN   = 28'sd52480;
	localparam logic signed [ACC_W-1:0] W_OTHER = 28'sd78592;
	localparam logic signed [ACC_W-1:0] W_TRI   = 28'sd307;
	localparam logic signed [ACC_W-1:0] W_NOISE = 28'sd6;
	localparam logic signed [MUL_W-1:0] W_OUT   = 42'sd7000;

	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_DEN     = 15'b000000000000010,
		ST_DIV     = 15'b000000000000100,
		ST_ENV     = 15'b000000000001000,
		ST_SWP0    = 15'b000000000010000,
		ST_SWP1    = 15'b000000000100000,
		ST_PULSE   = 15'b000000001000000,
		ST_TRI_A   = 15'b000000010000000,
		ST_TRI_B   = 15'b000000100000000,
		ST_NOISE   = 15'b000001000000000,
		ST_NADD    = 15'b000010000000000,
		ST_SCALE_L = 15'b000100000000000,
		ST_SCALE_R = 15'b001000000000000,
		ST_OUT     = 15'b010000000000000,
		ST_SPARE   = 15'b100000000000000
	} state_t;

	typedef enum logic [1:0] {
		TGT_P0  = 2'd0,
		TGT_P1  = 2'd1,
		TGT_TRI = 2'd2
	} tgt_t;

	state_t state_q;
	tgt_t   tgt_q;
	logic   tick_q;
	logic   sweep_hit_q;

	// configuration
	logic [3:0] chan_en_q;
	logic       play_q;

	// pulse channels
	logic [PHASE_BITS-1:0] pulse_phase_q [2];
	logic [PHASE_BITS-1:0] pulse_step_q [2];
	logic [10:0]           pulse_timer_q [2];
	logic [7:0]            pulse_control_q [2];
	logic [7:0]            sweep_control_q [2];
	logic [3:0]            sweep_count_q [2];
	logic [7:0]            period_lo_q [2];
	logic [2:0]            period_hi_q [2];
	env_t                  env_q [3];

	// triangle
	logic [PHASE_BITS-1:0] tri_phase_q;
	logic [PHASE_BITS-1:0] tri_step_q;
	logic [8:0]            tri_volume_q;
	logic [6:0]            tri_lin_q;
	logic [7:0]            tri_lo_q;
	logic [2:0]            tri_hi_q;

	// noise
	logic [14:0] noise_shift_q;
	logic [12:0] noise_accum_q;
	logic [5:0]  noise_ctl_q;
	logic        noise_tap_q;
	logic [3:0]  noise_per_q;

	// frame counters
	logic [TC_W-1:0] tick_count_q;
	logic [EC_W-1:0] env_ph_q;
	logic [SC_W-1:0] swp_ph_q;

	// mix datapath
	logic signed [ACC_W-1:0]  acc_l_q;
	logic signed [ACC_W-1:0]  acc_r_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MUL_W-1:0]  mul_q;
	logic signed [15:0]       res_l_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_l_q;
	logic signed [15:0] out_r_q;

	function automatic env_t env_step(input env_t e, input logic [3:0] vol, input logic loop);
		env_t r;
		r     = e;
		r.div = e.div + 5'd1;
		if (r.div >= {1'b0, vol} + 5'd2) begin
			r.div = 5'd1;
			if (e.level != 4'd0) begin
				r.level = e.level - 4'd1;
				if (r.level == 4'd0 && loop) r.level = 4'd15;
			end
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [MUL_W-1:0] m);
		logic signed [MUL_W-1:0]  adj;
		logic signed [MUL_W-25:0] q;
		adj = m[MUL_W-1] ? m + $signed(MUL_W'(24'hFFFFFF)) : m;
		q   = adj[MUL_W-1:24];
		if (q > 32767) return 16'sh7FFF;
		if (q < -32768) return 16'sh8000;
		return q[15:0];
	endfunction

	// ---------------- write decode ----------------
	logic        wr_p;
	logic [10:0] wr_timer;
	logic [7:0]  wr_lo;
	logic [2:0]  wr_hi;
	logic [10:0] wr_tri_per;
	logic        is_pulse_addr;

	always_comb begin
		wr_p          = head.item.reg_addr[2];
		is_pulse_addr = head.item.reg_addr inside {[4'd0:REG_PULSE_LAST]};
		wr_lo = (head.item.reg_addr[1:0] == PULSE_LO) ? head.item.reg_data : period_lo_q[wr_p];
		wr_hi = (head.item.reg_addr[1:0] == PULSE_HI) ? head.item.reg_data[2:0]
			: period_hi_q[wr_p];
		wr_timer   = {wr_hi, wr_lo};
		wr_tri_per = {(head.item.reg_addr == REG_TRI_HI) ? head.item.reg_data[2:0] : tri_hi_q,
			(head.item.reg_addr == REG_TRI_LO) ? head.item.reg_data : tri_lo_q};
	end

	// ---------------- step divider request ----------------
	logic [11:0] den_per;
	logic [27:0] den_prod;

	always_comb begin
		case (tgt_q)
			TGT_P0:  den_per = {1'b0, pulse_timer_q[0]} + 12'd1;
			TGT_P1:  den_per = {1'b0, pulse_timer_q[1]} + 12'd1;
			default: den_per = {1'b0, tri_hi_q, tri_lo_q} + 12'd1;
		endcase
		den_prod      = 28'(den_per) * 28'(MIX_HZ);
		div_req.start = (state_q == ST_DEN);
		div_req.den   = (tgt_q == TGT_TRI) ? DEN_W'({den_prod, 5'b0})
			: DEN_W'({den_prod, 4'b0});
	end

	// ---------------- sweep units ----------------
	logic [1:0]  sw_fire;
	logic [1:0]  sw_upd;
	logic [3:0]  sw_count [2];
	logic [10:0] sw_timer [2];

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			logic signed [12:0] per;
			logic signed [12:0] s;
			logic signed [12:0] v;
			logic               reach;
			per = $signed({2'b00, pulse_timer_q[p]});
			s   = $signed({2'b00, pulse_timer_q[p] >> sweep_control_q[p][2:0]});
			if (sweep_control_q[p][3]) v = per - s - ((p == 0) ? 13'sd1 : 13'sd0);
			else v = per + s;
			if (v < 0) sw_timer[p] = 11'd0;
			else if (v > 13'sd2047) sw_timer[p] = 11'd2047;
			else sw_timer[p] = v[10:0];
			reach = (sweep_count_q[p] + 4'd1) >= ({1'b0, sweep_control_q[p][6:4]} + 4'd1);
			sw_fire[p]  = sweep_hit_q && sweep_control_q[p][7];
			sw_count[p] = reach ? 4'd0 : sweep_count_q[p] + 4'd1;
			sw_upd[p]   = sw_fire[p] && reach && (sweep_control_q[p][2:0] != 3'd0);
		end
	end

	// ---------------- pulse mix terms ----------------
	logic [PHASE_BITS-1:0]   ph_next [2];
	logic [1:0]              p_live;
	logic signed [ACC_W-1:0] p_own [2];
	logic signed [ACC_W-1:0] p_oth [2];
	logic signed [ACC_W-1:0] pulse_l;
	logic signed [ACC_W-1:0] pulse_r;

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			logic [3:0]         vol;
			logic signed [9:0]  g;
			logic [PHASE_BITS-1:0] thr;
			p_live[p]  = (pulse_timer_q[p] >= 11'd8);
			ph_next[p] = pulse_phase_q[p] + pulse_step_q[p];
			vol = pulse_control_q[p][4] ? pulse_control_q[p][3:0] : env_q[p].level;
			g   = $signed({1'b0, gain_q8(vol)});
			thr = {duty_eighths(pulse_control_q[p][7:6]), {(PHASE_BITS-3){1'b0}}};
			if (ph_next[p] < thr) g = -g;
			if (p_live[p] && chan_en_q[p]) begin
				p_own[p] = ACC_W'(g) * W_OWN;
				p_oth[p] = ACC_W'(g) * W_OTHER;
			end else begin
				p_own[p] = '0;
				p_oth[p] = '0;
			end
		end
		pulse_l = p_own[0] + p_oth[1];
		pulse_r = p_oth[0] + p_own[1];
	end

	// ---------------- triangle terms ----------------
	logic [PHASE_BITS-1:0] tri_ph_next;
	logic [4:0]            tri_k;
	logic signed [9:0]     tri_amp;
	logic                  tri_gate;
	logic [8:0]            tri_vol_next;
	logic [9:0]            tri_vol_up;

	always_comb begin
		tri_ph_next = tri_phase_q + tri_step_q;
		tri_k       = tri_ph_next[PHASE_BITS-1 -: 5];
		tri_amp = tri_k[4] ? $signed({1'b0, tri_k[3:0], 5'b0}) - 10'sd256
			: 10'sd256 - $signed({1'b0, tri_k[3:0], 5'b0});
		tri_gate   = (tri_lin_q != 7'd0) && ({tri_hi_q, tri_lo_q} > 11'd1);
		tri_vol_up = {1'b0, tri_volume_q} + 10'd4;
		if (tri_gate) tri_vol_next = (tri_vol_up > 10'd256) ? 9'd256 : tri_vol_up[8:0];
		else tri_vol_next = (tri_volume_q < 9'd4) ? 9'd0 : tri_volume_q - 9'd4;
	end

	// ---------------- noise terms ----------------
	logic [11:0]       nz_per;
	logic              nz_run;
	logic [14:0]       nz_shift_next;
	logic [3:0]        nz_vol;
	logic signed [15:0] nz_centered;

	always_comb begin
		nz_per        = noise_period(noise_per_q);
		nz_run        = (noise_accum_q >= {1'b0, nz_per});
		nz_shift_next = {noise_shift_q[0] ^ (noise_tap_q ? noise_shift_q[6] : noise_shift_q[1]),
			noise_shift_q[14:1]};
		nz_vol        = noise_ctl_q[4] ? noise_ctl_q[3:0] : env_q[2].level;
		nz_centered   = $signed({1'b0, noise_shift_q}) - 16'sd16384;
	end

	// ---------------- handshakes ----------------
	assign pop                 = (state_q == ST_IDLE) && head.avail;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.left_sample  = out_l_q;
	assign out_ch.right_sample = out_r_q;

	// ---------------- sequencer and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tgt_q        <= TGT_P0;
			tick_q       <= 1'b0;
			sweep_hit_q  <= 1'b0;
			chan_en_q    <= 4'hF;
			play_q       <= 1'b1;
			out_valid_q  <= 1'b0;
			for (int p = 0; p < 2; p++) begin
				pulse_phase_q[p]   <= '0;
				pulse_step_q[p]    <= '0;
				pulse_timer_q[p]   <= '0;
				pulse_control_q[p] <= '0;
				sweep_control_q[p] <= '0;
				sweep_count_q[p]   <= '0;
				period_lo_q[p]     <= '0;
				period_hi_q[p]     <= '0;
			end
			for (int e = 0; e < 3; e++) env_q[e] <= '0;
			tri_phase_q   <= '0;
			tri_step_q    <= '0;
			tri_volume_q  <= '0;
			tri_lin_q     <= '0;
			tri_lo_q      <= '0;
			tri_hi_q      <= '0;
			noise_shift_q <= 15'd1;
			noise_accum_q <= '0;
			noise_ctl_q   <= '0;
			noise_tap_q   <= 1'b0;
			noise_per_q   <= '0;
			tick_count_q  <= '0;
			env_ph_q      <= '0;
			swp_ph_q      <= '0;
		end else begin
			// configuration port
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNEL_ENABLE: chan_en_q <= cfg_data;
					CFG_PLAY_ENABLE:    play_q <= cfg_data[0];
					default:            play_q <= play_q;
				endcase
			end

			// ST_OUT handles the accept itself when it reloads the register
			if (out_ch.valid && out_ch.ready && state_q != ST_OUT) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (head.avail) begin
						tick_q <= (head.item.kind == KIND_TICK);
						if (head.item.kind == KIND_TICK) begin
							state_q <= ST_ENV;
						end else if (is_pulse_addr) begin
							case (head.item.reg_addr[1:0])
								PULSE_CTL: begin
									pulse_control_q[wr_p] <= head.item.reg_data;
								end
								PULSE_SWEEP: begin
									sweep_control_q[wr_p] <= head.item.reg_data;
									sweep_count_q[wr_p]   <= '0;
								end
								default: begin
									period_lo_q[wr_p]   <= wr_lo;
									period_hi_q[wr_p]   <= wr_hi;
									pulse_timer_q[wr_p] <= wr_timer;
									sweep_count_q[wr_p] <= '0;
									if (head.item.reg_addr[1:0] == PULSE_HI)
										env_q[wr_p] <= '{level: 4'd15, div: 5'd0};
									tgt_q   <= wr_p ? TGT_P1 : TGT_P0;
									state_q <= ST_DEN;
								end
							endcase
						end else begin
							case (head.item.reg_addr)
								REG_TRI_LIN: tri_lin_q <= head.item.reg_data[6:0];
								REG_TRI_LO, REG_TRI_HI: begin
									tri_lo_q <= wr_tri_per[7:0];
									tri_hi_q <= wr_tri_per[10:8];
									if (wr_tri_per > 11'd1) begin
										tgt_q   <= TGT_TRI;
										state_q <= ST_DEN;
									end
								end
								REG_NOISE_CTL:  noise_ctl_q <= head.item.reg_data[5:0];
								REG_NOISE_MODE: begin
									noise_tap_q <= head.item.reg_data[7];
									noise_per_q <= head.item.reg_data[3:0];
								end
								REG_NOISE_ENV:  env_q[2] <= '{level: 4'd15, div: 5'd0};
								default:        state_q <= ST_IDLE;
							endcase
						end
					end
				end
				ST_DEN: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						case (tgt_q)
							TGT_P0:  pulse_step_q[0] <= div_quo;
							TGT_P1:  pulse_step_q[1] <= div_quo;
							default: tri_step_q <= div_quo;
						endcase
						if (!tick_q) state_q <= ST_IDLE;
						else if (tgt_q == TGT_P0) state_q <= ST_SWP1;
						else state_q <= ST_PULSE;
					end
				end
				ST_ENV: begin
					// frame sequencer: envelope and sweep clocks
					if (env_ph_q == '0) begin
						env_q[0] <= env_step(env_q[0], pulse_control_q[0][3:0],
							pulse_control_q[0][5]);
						env_q[1] <= env_step(env_q[1], pulse_control_q[1][3:0],
							pulse_control_q[1][5]);
						env_q[2] <= env_step(env_q[2], noise_ctl_q[3:0], noise_ctl_q[5]);
					end
					sweep_hit_q <= (swp_ph_q == '0);
					if (tick_count_q == TC_W'(TICKS_PER_FRAME - 1)) begin
						tick_count_q <= '0;
						env_ph_q     <= '0;
						swp_ph_q     <= '0;
					end else begin
						tick_count_q <= tick_count_q + 1'b1;
						env_ph_q <= (env_ph_q == EC_W'(ENV_DIV - 1)) ? '0 : env_ph_q + 1'b1;
						swp_ph_q <= (swp_ph_q == SC_W'(SWP_DIV - 1)) ? '0 : swp_ph_q + 1'b1;
					end
					state_q <= ST_SWP0;
				end
				ST_SWP0: begin
					if (sw_fire[0]) sweep_count_q[0] <= sw_count[0];
					if (sw_upd[0]) begin
						pulse_timer_q[0] <= sw_timer[0];
						tgt_q            <= TGT_P0;
						state_q          <= ST_DEN;
					end else begin
						state_q <= ST_SWP1;
					end
				end
				ST_SWP1: begin
					if (sw_fire[1]) sweep_count_q[1] <= sw_count[1];
					if (sw_upd[1]) begin
						pulse_timer_q[1] <= sw_timer[1];
						tgt_q            <= TGT_P1;
						state_q          <= ST_DEN;
					end else begin
						state_q <= ST_PULSE;
					end
				end
				ST_PULSE: begin
					if (!play_q) begin
						res_l_q <= '0;
						mul_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						for (int p = 0; p < 2; p++)
							if (p_live[p]) pulse_phase_q[p] <= ph_next[p];
						acc_l_q <= pulse_l;
						acc_r_q <= pulse_r;
						state_q <= ST_TRI_A;
					end
				end
				ST_TRI_A: begin
					tri_phase_q  <= tri_ph_next;
					tri_volume_q <= tri_vol_next;
					prod_q  <= PROD_W'(tri_amp) * PROD_W'($signed({1'b0, tri_vol_next}));
					state_q <= ST_TRI_B;
				end
				ST_TRI_B: begin
					if (chan_en_q[2]) begin
						acc_l_q <= acc_l_q + ACC_W'(prod_q) * W_TRI;
						acc_r_q <= acc_r_q + ACC_W'(prod_q) * W_TRI;
					end
					noise_accum_q <= noise_accum_q + 13'(NOISE_INC);
					state_q       <= ST_NOISE;
				end
				ST_NOISE: begin
					// one LFSR step per cycle until the accumulator drops below the period
					if (nz_run) begin
						noise_shift_q <= nz_shift_next;
						noise_accum_q <= noise_accum_q - {1'b0, nz_per};
					end else begin
						prod_q  <= PROD_W'(nz_centered) * PROD_W'($signed({1'b0, gain_q8(nz_vol)}));
						state_q <= ST_NADD;
					end
				end
				ST_NADD: begin
					if (chan_en_q[3]) begin
						acc_l_q <= acc_l_q + ACC_W'(prod_q) * W_NOISE;
						acc_r_q <= acc_r_q + ACC_W'(prod_q) * W_NOISE;
					end
					state_q <= ST_SCALE_L;
				end
				ST_SCALE_L: begin
					mul_q   <= MUL_W'(acc_l_q) * W_OUT;
					state_q <= ST_SCALE_R;
				end
				ST_SCALE_R: begin
					res_l_q <= sat16(mul_q);
					mul_q   <= MUL_W'(acc_r_q) * W_OUT;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_l_q     <= res_l_q;
						out_r_q     <= sat16(mul_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/scs_checker.sv
// Port-level checks for the sound channel synthesizer, bound to the top level.
// Depends on scs_pkg.
`timescale 1ns / 1ps
module scs_checker
	import scs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] left_sample,
	input logic [15:0] right_sample,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [3:0]  cfg_data
);

	logic       play_q;
	logic [2:0] pend_q;
	logic       tick_in;
	logic       word_out;

	assign tick_in  = in_valid && in_ready && (in_kind == KIND_TICK);
	assign word_out = out_valid && out_ready;

	// shadow of play enable and count of ticks owed a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= 1'b1;
			pend_q <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_PLAY_ENABLE) play_q <= cfg_data[0];
			pend_q <= pend_q + {2'b00, tick_in} - {2'b00, word_out};
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sample dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_sample) && $stable(right_sample))
		else $error("sample changed while stalled");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !play_q |-> left_sample == 16'd0 && right_sample == 16'd0)
		else $error("sample not silent with play disabled");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("sample without a tick");

endmodule

bind sound_channel_synthesizer scs_checker u_scs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_kind      (in_ch.kind),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.left_sample  (out_ch.left_sample),
	.right_sample (out_ch.right_sample),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

>>> test/tb_sound_channel_synthesizer.sv
// Testbench for sound_channel_synthesizer: directed and random register writes and sample
// ticks, checked sample by sample against a local model. Depends on scs_pkg and scs_if.
`timescale 1ns / 1ps
module tb_sound_channel_synthesizer;
	import scs_pkg::*;

	localparam int  FRAME_TICKS = 735;
	localparam int  PHASE_W     = 24;
	localparam longint PH_MASK  = (longint'(1) << PHASE_W) - 1;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  SETTLE      = 150;
	localparam int  RAND_WORDS  = 1325;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [3:0] cfg_data;

	scs_in_if  in_ch ();
	scs_out_if out_ch ();

	sound_channel_synthesizer dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stereo_t pending_samples[$];
	int  errors = 0;
	int  samples_seen = 0;
	int  words_sent = 0;
	int  cycles = 0;
	bit  no_idle = 1'b0;

	// local copy of the synthesizer state
	longint sq_phase[2], sq_inc[2];
	int     sq_period[2], sq_sweep_cnt[2];
	logic [7:0] sq_ctl[2], sq_sweep[2], sq_lo[2], sq_hi[2];
	int     env_lvl[3], env_div[3];
	longint tr_phase, tr_inc;
	int     tr_vol;
	logic [7:0] tr_lin, tr_lo, tr_hi, nz_ctl, nz_mode;
	int     nz_lfsr, nz_acc, frame_pos;
	logic [3:0] mix_mask;
	logic   run_en;

	function automatic longint osc_step(int period, int mult);
		return (longint'(CPU_HZ) << PHASE_W) /
			(longint'(mult) * longint'(period + 1) * longint'(MIX_HZ));
	endfunction

	function automatic longint level_gain(int v);
		return longint'((v * 256 + 7) / 15);
	endfunction

	function automatic logic signed [15:0] scale_sat(longint acc);
		longint v;
		v = acc * 7000 / 16777216;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic int tri_period();
		return int'(tr_lo) | (int'(tr_hi[2:0]) << 8);
	endfunction

	function automatic int duty_tbl(logic [1:0] d);
		case (d)
			2'd0: return 1;
			2'd1: return 2;
			2'd2: return 4;
			default: return 6;
		endcase
	endfunction

	function automatic int nz_len(logic [3:0] i);
		int t[16] = '{4, 8, 16, 32, 64, 96, 128, 160, 202, 254, 380, 508, 762, 1016, 2034, 4068};
		return t[i];
	endfunction

	task automatic model_reset();
		for (int i = 0; i < 2; i++) begin
			sq_phase[i] = 0; sq_inc[i] = 0; sq_period[i] = 0; sq_sweep_cnt[i] = 0;
			sq_ctl[i] = 0; sq_sweep[i] = 0; sq_lo[i] = 0; sq_hi[i] = 0;
		end
		for (int i = 0; i < 3; i++) begin
			env_lvl[i] = 0; env_div[i] = 0;
		end
		tr_phase = 0; tr_inc = 0; tr_vol = 0;
		tr_lin = 0; tr_lo = 0; tr_hi = 0; nz_ctl = 0; nz_mode = 0;
		nz_lfsr = 1; nz_acc = 0; frame_pos = 0;
		mix_mask = 4'hf; run_en = 1'b1;
	endtask

	function automatic void env_tick(int e, logic [7:0] ctl);
		env_div[e]++;
		if (env_div[e] >= int'(ctl[3:0]) + 2) begin
			env_div[e] = 1;
			if (env_lvl[e] > 0) begin
				env_lvl[e]--;
				if (env_lvl[e] == 0 && ctl[5]) env_lvl[e] = 15;
			end
		end
	endfunction

	function automatic int env_out(int e, logic [7:0] ctl);
		return ctl[4] ? int'(ctl[3:0]) : env_lvl[e];
	endfunction

	function automatic void sweep_tick(int p);
		int per, s;
		if (!sq_sweep[p][7]) return;
		sq_sweep_cnt[p]++;
		if (sq_sweep_cnt[p] >= int'(sq_sweep[p][6:4]) + 1) begin
			sq_sweep_cnt[p] = 0;
			if (sq_sweep[p][2:0] != 0) begin
				per = sq_period[p];
				s = per >>> sq_sweep[p][2:0];
				per += sq_sweep[p][3] ? (-s - (p == 0 ? 1 : 0)) : s;
				if (per < 0) per = 0;
				if (per > 2047) per = 2047;
				sq_period[p] = per;
				sq_inc[p] = osc_step(per, 16);
			end
		end
	endfunction

	// register write side of the model
	task automatic model_write(logic [3:0] a, logic [7:0] d);
		int p;
		p = a[2];
		if (a <= REG_PULSE_LAST) begin
			case (a[1:0])
				PULSE_CTL: sq_ctl[p] = d;
				PULSE_SWEEP: begin
					sq_sweep[p] = d;
					sq_sweep_cnt[p] = 0;
				end
				default: begin
					if (a[1:0] == PULSE_LO) sq_lo[p] = d;
					else sq_hi[p] = d;
					sq_period[p] = int'(sq_lo[p]) | (int'(sq_hi[p][2:0]) << 8);
					sq_inc[p] = osc_step(sq_period[p], 16);
					sq_sweep_cnt[p] = 0;
					if (a[1:0] == PULSE_HI) begin
						env_lvl[p] = 15; env_div[p] = 0;
					end
				end
			endcase
		end else if (a == REG_TRI_LIN || a == REG_TRI_LO || a == REG_TRI_HI) begin
			if (a == REG_TRI_LIN) tr_lin = d;
			else if (a == REG_TRI_LO) tr_lo = d;
			else tr_hi = d;
			if (tri_period() > 1) tr_inc = osc_step(tri_period(), 32);
		end else if (a == REG_NOISE_CTL) nz_ctl = d;
		else if (a == REG_NOISE_MODE) nz_mode = d;
		else if (a == REG_NOISE_ENV) begin
			env_lvl[2] = 15; env_div[2] = 0;
		end
	endtask

	// sample tick side of the model: yields one stereo word
	function automatic stereo_t model_tick();
		stereo_t r;
		longint lsum, rsum, g, amp, c;
		int k, per, tap, b;
		lsum = 0; rsum = 0;
		if (frame_pos % (FRAME_TICKS / 4) == 0) begin
			env_tick(0, sq_ctl[0]); env_tick(1, sq_ctl[1]); env_tick(2, nz_ctl);
		end
		if (frame_pos % (FRAME_TICKS / 2) == 0) begin
			sweep_tick(0); sweep_tick(1);
		end
		frame_pos++;
		if (frame_pos >= FRAME_TICKS) frame_pos = 0;
		r.left = 0; r.right = 0;
		if (!run_en) return r;
		for (int p = 0; p < 2; p++) begin
			if (sq_period[p] >= 8) begin
				sq_phase[p] = (sq_phase[p] + sq_inc[p]) & PH_MASK;
				g = level_gain(env_out(p, sq_ctl[p]));
				if (sq_phase[p] < (longint'(duty_tbl(sq_ctl[p][7:6])) << (PHASE_W - 3))) g = -g;
				if (mix_mask[p]) begin
					if (p == 0) begin
						lsum += g * 205 * 256; rsum += g * 307 * 256;
					end else begin
						rsum += g * 205 * 256; lsum += g * 307 * 256;
					end
				end
			end
		end
		// triangle with volume ramp
		tr_phase = (tr_phase + tr_inc) & PH_MASK;
		k = int'((tr_phase >> (PHASE_W - 5)) & 31);
		amp = k < 16 ? 256 - 32 * k : 32 * (k - 16) - 256;
		if (tr_lin[6:0] != 0 && tri_period() > 1) tr_vol = tr_vol + 4 > 256 ? 256 : tr_vol + 4;
		else tr_vol = tr_vol < 4 ? 0 : tr_vol - 4;
		c = amp * tr_vol * 307;
		if (mix_mask[2]) begin
			lsum += c; rsum += c;
		end
		// noise LFSR
		per = nz_len(nz_mode[3:0]);
		tap = nz_mode[7] ? 6 : 1;
		nz_acc += CPU_HZ / MIX_HZ;
		while (nz_acc >= per) begin
			b = nz_lfsr ^ (nz_lfsr >> tap);
			nz_acc -= per;
			nz_lfsr = ((nz_lfsr >> 1) | ((b & 1) << 14)) & 32'h7fff;
		end
		c = longint'(nz_lfsr - 16384) * level_gain(env_out(2, nz_ctl)) * 6;
		if (mix_mask[3]) begin
			lsum += c; rsum += c;
		end
		r.left = scale_sat(lsum);
		r.right = scale_sat(rsum);
		return r;
	endfunction

	// sends one word, sometimes with a random gap before it
	task automatic send_word(logic k, logic [3:0] a, logic [7:0] d);
		if (!no_idle && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.reg_addr <= a;
		in_ch.reg_data <= d;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		if (k == KIND_TICK) pending_samples.push_back(model_tick());
		else model_write(a, d);
	endtask

	task automatic reg_wr(logic [3:0] a, logic [7:0] d);
		send_word(KIND_WRITE, a, d);
	endtask

	task automatic ticks(int n);
		for (int i = 0; i < n; i++) send_word(KIND_TICK, 4'($urandom), 8'($urandom));
	endtask

	// waits until the block is idle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [3:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHANNEL_ENABLE) mix_mask = val;
		else run_en = val[0];
	endtask

	// output ready with random stalls
	always @(posedge clk)
		out_ch.ready <= no_idle || ($urandom_range(99) >= 11);

	// result checker
	always @(posedge clk) begin : check_samples
		stereo_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			samples_seen++;
			if (pending_samples.size() == 0) begin
				$error("sample with none expected: %0d %0d", out_ch.left_sample,
					out_ch.right_sample);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (out_ch.left_sample !== want.left) begin
					$error("left_sample expected %0d got %0d", want.left, out_ch.left_sample);
					errors++;
				end
				if (out_ch.right_sample !== want.right) begin
					$error("right_sample expected %0d got %0d", want.right,
						out_ch.right_sample);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_pulses();
		reg_wr(4'd0, 8'hbf);
		reg_wr(4'd2, 8'hff);
		reg_wr(4'd3, 8'h07);
		ticks(2);
		reg_wr(4'd4, 8'h00);
		reg_wr(4'd5, 8'h89);
		reg_wr(4'd6, 8'h03);
		reg_wr(4'd7, 8'h00);
		ticks(1);
	endtask

	task automatic test_triangle();
		reg_wr(REG_TRI_LIN, 8'h7f);
		reg_wr(REG_TRI_LO, 8'h01);
		reg_wr(REG_TRI_HI, 8'h00);
		ticks(1);
		reg_wr(REG_TRI_LO, 8'hff);
		ticks(1);
	endtask

	task automatic test_noise_unused();
		reg_wr(REG_NOISE_CTL, 8'h3f);
		reg_wr(REG_NOISE_MODE, 8'h80);
		reg_wr(REG_NOISE_ENV, 8'haa);
		ticks(1);
		reg_wr(4'd9, 8'hff);
		reg_wr(4'd13, 8'hff);
		ticks(1);
	endtask

	task automatic test_config();
		write_cfg(CFG_CHANNEL_ENABLE, 4'h0);
		ticks(2);
		write_cfg(CFG_PLAY_ENABLE, 4'h0);
		ticks(2);
		write_cfg(CFG_PLAY_ENABLE, 4'h1);
		write_cfg(CFG_CHANNEL_ENABLE, 4'hf);
		ticks(2);
	endtask

	// random phrases: program one channel, then a burst of ticks, or six random words; config changes between phases
	task automatic test_random();
		int n, ch, phase_mark;
		logic [3:0] base;
		n = 0;
		phase_mark = 0;
		while (n < RAND_WORDS) begin
			no_idle = (n > 600 && n < 800);
			if (n - phase_mark > 300) begin
				phase_mark = n;
				write_cfg(CFG_CHANNEL_ENABLE, $urandom_range(3) == 0 ?
					($urandom_range(1) ? 4'h0 : 4'hf) : 4'($urandom));
				write_cfg(CFG_PLAY_ENABLE, 4'($urandom_range(5) != 0));
			end
			if ($urandom_range(9) < 8) begin
				ch = $urandom_range(3);
				if (ch < 2) begin
					base = 4'(ch * 4);
					reg_wr(base, 8'($urandom));
					reg_wr(base + 4'd1, $urandom_range(1) ? (8'($urandom) | 8'h80) :
						8'($urandom));
					reg_wr(base + 4'd2, 8'($urandom));
					reg_wr(base + 4'd3, 8'($urandom));
					n += 4;
				end else if (ch == 2) begin
					reg_wr(REG_TRI_LIN, 8'($urandom));
					reg_wr(REG_TRI_LO, $urandom_range(7) == 0 ? 8'($urandom_range(1)) :
						8'($urandom));
					reg_wr(REG_TRI_HI, 8'($urandom));
					n += 3;
				end else begin
					reg_wr(REG_NOISE_CTL, 8'($urandom));
					reg_wr(REG_NOISE_MODE, 8'($urandom));
					reg_wr(REG_NOISE_ENV, 8'($urandom));
					n += 3;
				end
				ch = $urandom_range(40, 5);
				ticks(ch);
				n += ch;
			end else begin
				for (int i = 0; i < 6; i++)
					send_word(1'($urandom), 4'($urandom), 8'($urandom));
				n += 6;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 4'h0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_WRITE;
		in_ch.reg_addr = 4'h0;
		in_ch.reg_data = 8'h00;
		out_ch.ready = 1'b0;
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		ticks(1);
		test_pulses();
		test_triangle();
		test_noise_unused();
		test_config();
		test_random();
		drain();
		if (pending_samples.size() != 0) begin
			$error("%0d samples never arrived", pending_samples.size());
			errors++;
		end
		$display("Sent %0d words over all sound registers, checked %0d stereo samples,",
			words_sent, samples_seen);
		$display("with channel masks and play on/off varied between phases.");
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
